// ===== rtl/ecc_pkg.sv =====
// Shared types, codes and payload structures of the affine point arithmetic block.
`timescale 1ns / 1ps

package ecc_pkg;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 64;
  localparam int FLD_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CURVE_A = 1'd1;

  typedef enum logic [1:0] {
    CMD_ADD  = 2'd0,
    CMD_DBL  = 2'd1,
    CMD_MUL  = 2'd2,
    CMD_PASS = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [FLD_W-1:0] p_x;
    logic [FLD_W-1:0] p_y;
    logic             p_at_infinity;
    logic [FLD_W-1:0] q_x;
    logic [FLD_W-1:0] q_y;
    logic             q_at_infinity;
    logic [FLD_W-1:0] scalar;
  } in_item_t;

  typedef struct packed {
    logic [FLD_W-1:0] r_x;
    logic [FLD_W-1:0] r_y;
    logic             r_at_infinity;
  } out_item_t;

  typedef enum logic [3:0] {
    SEL_PX, SEL_PY, SEL_QX, SEL_QY, SEL_AX, SEL_AY,
    SEL_T0, SEL_T1, SEL_T2, SEL_ONE, SEL_CA
  } reg_sel_t;

  typedef enum logic [2:0] {
    OP_NONE, OP_ADD, OP_SUB, OP_MUL, OP_INV, OP_MOV, OP_KSHR
  } dp_op_t;

  typedef struct packed {
    logic     go;
    dp_op_t   op;
    reg_sel_t dst;
    reg_sel_t src_a;
    reg_sel_t src_b;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
    logic eq;
    logic a_zero;
    logic k_zero;
    logic k_lsb;
  } dp_stat_t;

  typedef enum logic [2:0] {
    DP_IDLE, DP_MUL, DP_INV_CHK, DP_INV_R, DP_INV_B
  } dp_state_t;

  typedef enum logic [6:0] {
    C_IDLE, C_LD0, C_LD1, C_LD2, C_LD3,
    C_P3_X, C_P3_Y,
    C_AC_X, C_AC_Y,
    C_DC_X, C_DC_Y, C_DC_FX, C_DC_FY,
    C_MC_X, C_MC_Y, C_M_TEST, C_M_DBL, C_M_SHR,
    C_ADD, C_ADD_EQX, C_ADD_EQY, C_ACP_X, C_ACP_Y,
    C_AD_0, C_AD_1, C_AD_2, C_AD_3, C_AD_4, C_AD_5, C_AD_6, C_AD_7, C_AD_8,
    C_AD_9, C_AD_10,
    C_DBL,
    C_DB_0, C_DB_1, C_DB_2, C_DB_3, C_DB_4, C_DB_5, C_DB_6, C_DB_7, C_DB_8,
    C_DB_9, C_DB_10, C_DB_11, C_DB_12, C_DB_13, C_DB_14,
    C_OUT
  } ctl_state_t;

  function automatic dp_cmd_t mk_cmd(dp_op_t op, reg_sel_t dst, reg_sel_t a, reg_sel_t b);
    dp_cmd_t c;
    c.go = 1'b1;
    c.op = op;
    c.dst = dst;
    c.src_a = a;
    c.src_b = b;
    return c;
  endfunction

  function automatic dp_cmd_t mk_test(reg_sel_t a, reg_sel_t b);
    dp_cmd_t c;
    c.go = 1'b0;
    c.op = OP_NONE;
    c.dst = SEL_T0;
    c.src_a = a;
    c.src_b = b;
    return c;
  endfunction

endpackage

// ===== rtl/ecc_stream_if.sv =====
// Valid/ready channel carrying one payload structure.
`timescale 1ns / 1ps

interface ecc_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/ecc_dp.sv =====
// Datapath: field registers, serial modular multiplier, inverse by exponentiation.
`timescale 1ns / 1ps

module ecc_dp #(
  parameter int W = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  ecc_pkg::dp_cmd_t                   cmd,
  output ecc_pkg::dp_stat_t                  stat,
  input  logic                               load,
  input  ecc_pkg::in_item_t                  item,
  input  logic                               cfg_we,
  input  logic [ecc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ecc_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic [W-1:0]                       acc_x,
  output logic [W-1:0]                       acc_y
);
  import ecc_pkg::*;

  localparam int CNT_W = $clog2(W);

  dp_state_t state, state_next;
  logic done, done_next;

  logic [W-1:0] px, py, qx, qy, ax, ay, t0, t1, t2;
  logic [W-1:0] m, ca;
  logic [FLD_W-1:0] k;
  logic [W-1:0] mx, my, mr, mr_next, r2;
  logic [CNT_W-1:0] mcnt;
  logic mlast;
  logic [W-1:0] er, eb, e;
  logic [W-1:0] oa, ob;
  logic [W-1:0] mx_in, my_in, wr_data;
  logic m_load, wr_en, inv_init, er_we, eb_we, e_shift, k_shr, start;

  function automatic logic [W-1:0] add_m(logic [W-1:0] x, logic [W-1:0] y,
                                         logic [W-1:0] md);
    logic [W:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, md}) s = s - {1'b0, md};
    return s[W-1:0];
  endfunction

  function automatic logic [W-1:0] sub_m(logic [W-1:0] x, logic [W-1:0] y,
                                         logic [W-1:0] md);
    logic [W-1:0] d;
    if (x >= y) d = x - y;
    else d = md - (y - x);
    return d;
  endfunction

  always_comb begin
    case (cmd.src_a)
      SEL_PX:  oa = px;
      SEL_PY:  oa = py;
      SEL_QX:  oa = qx;
      SEL_QY:  oa = qy;
      SEL_AX:  oa = ax;
      SEL_AY:  oa = ay;
      SEL_T0:  oa = t0;
      SEL_T1:  oa = t1;
      SEL_T2:  oa = t2;
      SEL_ONE: oa = W'(1);
      SEL_CA:  oa = ca;
      default: oa = '0;
    endcase
  end

  always_comb begin
    case (cmd.src_b)
      SEL_PX:  ob = px;
      SEL_PY:  ob = py;
      SEL_QX:  ob = qx;
      SEL_QY:  ob = qy;
      SEL_AX:  ob = ax;
      SEL_AY:  ob = ay;
      SEL_T0:  ob = t0;
      SEL_T1:  ob = t1;
      SEL_T2:  ob = t2;
      SEL_ONE: ob = W'(1);
      SEL_CA:  ob = ca;
      default: ob = '0;
    endcase
  end

  always_comb begin
    r2 = add_m(mr, mr, m);
    mr_next = my[mcnt] ? add_m(r2, mx, m) : r2;
    mlast = (mcnt == '0);
  end

  always_comb begin
    state_next = state;
    done_next = 1'b0;
    wr_en = 1'b0;
    wr_data = '0;
    m_load = 1'b0;
    mx_in = '0;
    my_in = '0;
    inv_init = 1'b0;
    er_we = 1'b0;
    eb_we = 1'b0;
    e_shift = 1'b0;
    k_shr = 1'b0;
    start = cmd.go && !done;
    case (state)
      DP_IDLE: begin
        if (start) begin
          case (cmd.op)
            OP_ADD: begin
              wr_en = 1'b1;
              wr_data = add_m(oa, ob, m);
              done_next = 1'b1;
            end
            OP_SUB: begin
              wr_en = 1'b1;
              wr_data = sub_m(oa, ob, m);
              done_next = 1'b1;
            end
            OP_MOV: begin
              wr_en = 1'b1;
              wr_data = oa;
              done_next = 1'b1;
            end
            OP_KSHR: begin
              k_shr = 1'b1;
              done_next = 1'b1;
            end
            OP_MUL: begin
              m_load = 1'b1;
              mx_in = oa;
              my_in = ob;
              state_next = DP_MUL;
            end
            OP_INV: begin
              inv_init = 1'b1;
              state_next = DP_INV_CHK;
            end
            default: done_next = 1'b1;
          endcase
        end
      end
      DP_MUL: begin
        if (mlast) begin
          wr_en = 1'b1;
          wr_data = mr_next;
          done_next = 1'b1;
          state_next = DP_IDLE;
        end
      end
      DP_INV_CHK: begin
        if (e == '0) begin
          wr_en = 1'b1;
          wr_data = er;
          done_next = 1'b1;
          state_next = DP_IDLE;
        end else if (e[0]) begin
          m_load = 1'b1;
          mx_in = er;
          my_in = eb;
          state_next = DP_INV_R;
        end else begin
          m_load = 1'b1;
          mx_in = eb;
          my_in = eb;
          state_next = DP_INV_B;
        end
      end
      DP_INV_R: begin
        if (mlast) begin
          er_we = 1'b1;
          m_load = 1'b1;
          mx_in = eb;
          my_in = eb;
          state_next = DP_INV_B;
        end
      end
      DP_INV_B: begin
        if (mlast) begin
          eb_we = 1'b1;
          e_shift = 1'b1;
          state_next = DP_INV_CHK;
        end
      end
      default: state_next = DP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DP_IDLE;
      done <= 1'b0;
      m <= W'(3);
      ca <= '0;
    end else begin
      state <= state_next;
      done <= done_next;
      if (cfg_we) begin
        case (cfg_index)
          CFG_MODULUS: m <= (cfg_data[W-1:0] < W'(3)) ? W'(3) : cfg_data[W-1:0];
          CFG_CURVE_A: ca <= cfg_data[W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (m_load) begin
      mx <= mx_in;
      my <= my_in;
      mr <= '0;
      mcnt <= CNT_W'(W - 1);
    end else begin
      mr <= mr_next;
      mcnt <= mcnt - CNT_W'(1);
    end
    if (inv_init) begin
      eb <= oa;
      er <= W'(1);
      e <= m - W'(2);
    end else begin
      if (er_we) er <= mr_next;
      if (eb_we) eb <= mr_next;
      if (e_shift) e <= e >> 1;
    end
    if (load) begin
      px <= item.p_x[W-1:0];
      py <= item.p_y[W-1:0];
      qx <= item.q_x[W-1:0];
      qy <= item.q_y[W-1:0];
      k <= item.scalar;
    end else if (k_shr) begin
      k <= k >> 1;
    end
    if (wr_en) begin
      case (cmd.dst)
        SEL_PX: px <= wr_data;
        SEL_PY: py <= wr_data;
        SEL_QX: qx <= wr_data;
        SEL_QY: qy <= wr_data;
        SEL_AX: ax <= wr_data;
        SEL_AY: ay <= wr_data;
        SEL_T0: t0 <= wr_data;
        SEL_T1: t1 <= wr_data;
        SEL_T2: t2 <= wr_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    stat.done = done;
    stat.eq = (oa == ob);
    stat.a_zero = (oa == '0);
    stat.k_zero = (k == '0);
    stat.k_lsb = k[0];
  end

  assign acc_x = ax;
  assign acc_y = ay;

endmodule

// ===== rtl/ecc_ctl.sv =====
// Controller: sequences point add, point double and scalar multiply on the datapath.
`timescale 1ns / 1ps

module ecc_ctl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_cmd,
  input  logic              in_p_inf,
  input  logic              in_q_inf,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              r_inf,
  output ecc_pkg::dp_cmd_t  cmd,
  input  ecc_pkg::dp_stat_t stat
);
  import ecc_pkg::*;

  ctl_state_t state, state_next;
  ctl_state_t add_ret, add_ret_next;
  ctl_state_t dbl_ret, dbl_ret_next;
  cmd_t op_cmd;
  logic pinf, qinf, qinf_next, ainf, ainf_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      add_ret <= C_OUT;
      dbl_ret <= C_OUT;
      op_cmd <= CMD_ADD;
      pinf <= 1'b0;
      qinf <= 1'b0;
      ainf <= 1'b0;
    end else begin
      state <= state_next;
      add_ret <= add_ret_next;
      dbl_ret <= dbl_ret_next;
      qinf <= qinf_next;
      ainf <= ainf_next;
      if (in_valid && in_ready) begin
        op_cmd <= cmd_t'(in_cmd);
        pinf <= in_p_inf;
        qinf <= in_q_inf;
      end
    end
  end

  always_comb begin
    state_next = state;
    add_ret_next = add_ret;
    dbl_ret_next = dbl_ret;
    qinf_next = qinf;
    ainf_next = ainf;
    in_ready = 1'b0;
    out_valid = 1'b0;
    cmd = mk_test(SEL_AX, SEL_QX);
    case (state)
      C_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = C_LD0;
      end
      C_LD0: begin
        cmd = mk_cmd(OP_MUL, SEL_PX, SEL_ONE, SEL_PX);
        if (stat.done) state_next = C_LD1;
      end
      C_LD1: begin
        cmd = mk_cmd(OP_MUL, SEL_PY, SEL_ONE, SEL_PY);
        if (stat.done) state_next = C_LD2;
      end
      C_LD2: begin
        cmd = mk_cmd(OP_MUL, SEL_QX, SEL_ONE, SEL_QX);
        if (stat.done) state_next = C_LD3;
      end
      C_LD3: begin
        cmd = mk_cmd(OP_MUL, SEL_QY, SEL_ONE, SEL_QY);
        if (stat.done) begin
          case (op_cmd)
            CMD_ADD: state_next = C_AC_X;
            CMD_DBL: state_next = C_DC_X;
            CMD_MUL: state_next = C_MC_X;
            default: state_next = C_P3_X;
          endcase
        end
      end
      C_P3_X: begin
        cmd = mk_cmd(OP_MOV, SEL_AX, SEL_PX, SEL_PX);
        if (stat.done) state_next = C_P3_Y;
      end
      C_P3_Y: begin
        cmd = mk_cmd(OP_MOV, SEL_AY, SEL_PY, SEL_PY);
        if (stat.done) begin
          ainf_next = pinf;
          state_next = C_OUT;
        end
      end
      C_AC_X: begin
        cmd = mk_cmd(OP_MOV, SEL_AX, SEL_PX, SEL_PX);
        if (stat.done) state_next = C_AC_Y;
      end
      C_AC_Y: begin
        cmd = mk_cmd(OP_MOV, SEL_AY, SEL_PY, SEL_PY);
        if (stat.done) begin
          ainf_next = pinf;
          add_ret_next = C_OUT;
          state_next = C_ADD;
        end
      end
      C_DC_X: begin
        cmd = mk_cmd(OP_MOV, SEL_QX, SEL_PX, SEL_PX);
        if (stat.done) state_next = C_DC_Y;
      end
      C_DC_Y: begin
        cmd = mk_cmd(OP_MOV, SEL_QY, SEL_PY, SEL_PY);
        if (stat.done) begin
          qinf_next = pinf;
          dbl_ret_next = C_DC_FX;
          state_next = C_DBL;
        end
      end
      C_DC_FX: begin
        cmd = mk_cmd(OP_MOV, SEL_AX, SEL_QX, SEL_QX);
        if (stat.done) state_next = C_DC_FY;
      end
      C_DC_FY: begin
        cmd = mk_cmd(OP_MOV, SEL_AY, SEL_QY, SEL_QY);
        if (stat.done) begin
          ainf_next = qinf;
          state_next = C_OUT;
        end
      end
      C_MC_X: begin
        cmd = mk_cmd(OP_MOV, SEL_QX, SEL_PX, SEL_PX);
        if (stat.done) state_next = C_MC_Y;
      end
      C_MC_Y: begin
        cmd = mk_cmd(OP_MOV, SEL_QY, SEL_PY, SEL_PY);
        if (stat.done) begin
          qinf_next = pinf;
          ainf_next = 1'b1;
          state_next = C_M_TEST;
        end
      end
      C_M_TEST: begin
        if (stat.k_zero || qinf) begin
          state_next = C_OUT;
        end else if (stat.k_lsb) begin
          add_ret_next = C_M_DBL;
          state_next = C_ADD;
        end else begin
          state_next = C_M_DBL;
        end
      end
      C_M_DBL: begin
        dbl_ret_next = C_M_SHR;
        state_next = C_DBL;
      end
      C_M_SHR: begin
        cmd = mk_cmd(OP_KSHR, SEL_T0, SEL_T0, SEL_T0);
        if (stat.done) state_next = C_M_TEST;
      end
      C_ADD: begin
        if (ainf) state_next = C_ACP_X;
        else if (qinf) state_next = add_ret;
        else state_next = C_ADD_EQX;
      end
      C_ADD_EQX: begin
        cmd = mk_test(SEL_AX, SEL_QX);
        state_next = stat.eq ? C_ADD_EQY : C_AD_0;
      end
      C_ADD_EQY: begin
        cmd = mk_test(SEL_AY, SEL_QY);
        if (stat.eq) begin
          dbl_ret_next = C_ACP_X;
          // Q is doubled in place: skip the running-point double that follows
          if (add_ret == C_M_DBL) add_ret_next = C_M_SHR;
          state_next = C_DBL;
        end else begin
          ainf_next = 1'b1;
          state_next = add_ret;
        end
      end
      C_ACP_X: begin
        cmd = mk_cmd(OP_MOV, SEL_AX, SEL_QX, SEL_QX);
        if (stat.done) state_next = C_ACP_Y;
      end
      C_ACP_Y: begin
        cmd = mk_cmd(OP_MOV, SEL_AY, SEL_QY, SEL_QY);
        if (stat.done) begin
          ainf_next = qinf;
          state_next = add_ret;
        end
      end
      C_AD_0: begin
        cmd = mk_cmd(OP_SUB, SEL_T0, SEL_QY, SEL_AY);
        if (stat.done) state_next = C_AD_1;
      end
      C_AD_1: begin
        cmd = mk_cmd(OP_SUB, SEL_T1, SEL_QX, SEL_AX);
        if (stat.done) state_next = C_AD_2;
      end
      C_AD_2: begin
        cmd = mk_cmd(OP_INV, SEL_T1, SEL_T1, SEL_T1);
        if (stat.done) state_next = C_AD_3;
      end
      C_AD_3: begin
        cmd = mk_cmd(OP_MUL, SEL_T0, SEL_T0, SEL_T1);
        if (stat.done) state_next = C_AD_4;
      end
      C_AD_4: begin
        cmd = mk_cmd(OP_MUL, SEL_T1, SEL_T0, SEL_T0);
        if (stat.done) state_next = C_AD_5;
      end
      C_AD_5: begin
        cmd = mk_cmd(OP_SUB, SEL_T1, SEL_T1, SEL_AX);
        if (stat.done) state_next = C_AD_6;
      end
      C_AD_6: begin
        cmd = mk_cmd(OP_SUB, SEL_T1, SEL_T1, SEL_QX);
        if (stat.done) state_next = C_AD_7;
      end
      C_AD_7: begin
        cmd = mk_cmd(OP_SUB, SEL_T2, SEL_AX, SEL_T1);
        if (stat.done) state_next = C_AD_8;
      end
      C_AD_8: begin
        cmd = mk_cmd(OP_MUL, SEL_T2, SEL_T0, SEL_T2);
        if (stat.done) state_next = C_AD_9;
      end
      C_AD_9: begin
        cmd = mk_cmd(OP_SUB, SEL_AY, SEL_T2, SEL_AY);
        if (stat.done) state_next = C_AD_10;
      end
      C_AD_10: begin
        cmd = mk_cmd(OP_MOV, SEL_AX, SEL_T1, SEL_T1);
        if (stat.done) begin
          ainf_next = 1'b0;
          state_next = add_ret;
        end
      end
      C_DBL: begin
        cmd = mk_test(SEL_QY, SEL_QY);
        if (qinf || stat.a_zero) begin
          qinf_next = 1'b1;
          state_next = dbl_ret;
        end else begin
          state_next = C_DB_0;
        end
      end
      C_DB_0: begin
        cmd = mk_cmd(OP_MUL, SEL_T2, SEL_ONE, SEL_CA);
        if (stat.done) state_next = C_DB_1;
      end
      C_DB_1: begin
        cmd = mk_cmd(OP_MUL, SEL_T0, SEL_QX, SEL_QX);
        if (stat.done) state_next = C_DB_2;
      end
      C_DB_2: begin
        cmd = mk_cmd(OP_ADD, SEL_T1, SEL_T0, SEL_T0);
        if (stat.done) state_next = C_DB_3;
      end
      C_DB_3: begin
        cmd = mk_cmd(OP_ADD, SEL_T1, SEL_T1, SEL_T0);
        if (stat.done) state_next = C_DB_4;
      end
      C_DB_4: begin
        cmd = mk_cmd(OP_ADD, SEL_T1, SEL_T1, SEL_T2);
        if (stat.done) state_next = C_DB_5;
      end
      C_DB_5: begin
        cmd = mk_cmd(OP_ADD, SEL_T2, SEL_QY, SEL_QY);
        if (stat.done) state_next = C_DB_6;
      end
      C_DB_6: begin
        cmd = mk_cmd(OP_INV, SEL_T2, SEL_T2, SEL_T2);
        if (stat.done) state_next = C_DB_7;
      end
      C_DB_7: begin
        cmd = mk_cmd(OP_MUL, SEL_T0, SEL_T1, SEL_T2);
        if (stat.done) state_next = C_DB_8;
      end
      C_DB_8: begin
        cmd = mk_cmd(OP_MUL, SEL_T1, SEL_T0, SEL_T0);
        if (stat.done) state_next = C_DB_9;
      end
      C_DB_9: begin
        cmd = mk_cmd(OP_SUB, SEL_T1, SEL_T1, SEL_QX);
        if (stat.done) state_next = C_DB_10;
      end
      C_DB_10: begin
        cmd = mk_cmd(OP_SUB, SEL_T1, SEL_T1, SEL_QX);
        if (stat.done) state_next = C_DB_11;
      end
      C_DB_11: begin
        cmd = mk_cmd(OP_SUB, SEL_T2, SEL_QX, SEL_T1);
        if (stat.done) state_next = C_DB_12;
      end
      C_DB_12: begin
        cmd = mk_cmd(OP_MUL, SEL_T2, SEL_T0, SEL_T2);
        if (stat.done) state_next = C_DB_13;
      end
      C_DB_13: begin
        cmd = mk_cmd(OP_SUB, SEL_QY, SEL_T2, SEL_QY);
        if (stat.done) state_next = C_DB_14;
      end
      C_DB_14: begin
        cmd = mk_cmd(OP_MOV, SEL_QX, SEL_T1, SEL_T1);
        if (stat.done) state_next = dbl_ret;
      end
      C_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_next = C_IDLE;
      end
      default: state_next = C_IDLE;
    endcase
  end

  assign r_inf = ainf;

endmodule

// ===== rtl/ecc_affine_point_arith.sv =====
// Top level of the affine elliptic-curve point add, double and scalar multiply block.
`timescale 1ns / 1ps

// One transaction in, one result out, one transaction at a time. Multiplications and
// inverses run on a single shared modular multiplier that retires one bit of its
// multiplier operand per cycle; additions and subtractions do not use it. An inverse
// is computed as v^(p-2) mod p and costs up to 2*FIELD_WIDTH multiplications.
// Loading reduces the four input coordinates modulo p, one multiplication each. A
// scalar multiply iterates over the scalar up to its highest set bit, with a double per
// bit and an add per set bit.
// Configuration writes take effect the cycle after the write enable.
module ecc_affine_point_arith #(
  parameter int FIELD_WIDTH = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  ecc_stream_if.sink                     in_ch,
  ecc_stream_if.source                   out_ch,
  input  logic                           cfg_we,
  input  logic [ecc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ecc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ecc_pkg::*;

  dp_cmd_t  dcmd;
  dp_stat_t dstat;
  logic [FIELD_WIDTH-1:0] acc_x, acc_y;
  logic in_ready, out_valid, r_inf;
  logic load;

  assign load = in_ch.valid && in_ready;

  ecc_ctl u_ctl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .in_cmd    (in_ch.data.cmd),
    .in_p_inf  (in_ch.data.p_at_infinity),
    .in_q_inf  (in_ch.data.q_at_infinity),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .r_inf     (r_inf),
    .cmd       (dcmd),
    .stat      (dstat)
  );

  ecc_dp #(.W(FIELD_WIDTH)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (dcmd),
    .stat      (dstat),
    .load      (load),
    .item      (in_ch.data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .acc_x     (acc_x),
    .acc_y     (acc_y)
  );

  assign in_ch.ready = in_ready;
  assign out_ch.valid = out_valid;
  assign out_ch.data.r_x = r_inf ? '0 : FLD_W'(acc_x);
  assign out_ch.data.r_y = r_inf ? FLD_W'(1) : FLD_W'(acc_y);
  assign out_ch.data.r_at_infinity = r_inf;

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !in_ch.ready)
    else $error("input taken while a result is pending");

  a_inf_encoding: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.data.r_at_infinity |->
      out_ch.data.r_x == '0 && out_ch.data.r_y == FLD_W'(1))
    else $error("infinity result not in canonical form");

  a_ready_after_out: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.ready |=> in_ch.ready && !out_ch.valid)
    else $error("block not idle after result transaction");

  a_no_out_after_in: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |=> !out_ch.valid && !in_ch.ready)
    else $error("result or input taken right after input transaction");

endmodule

// ===== bench/ecc_affine_point_arith_tb.sv =====
// Self-checking testbench of the affine point add, double and scalar multiply block.
`timescale 1ns / 1ps

module ecc_affine_point_arith_tb;
  import ecc_pkg::*;

  localparam longint unsigned CYCLE_LIMIT = 12_000_000;
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] BIG_PRIME = 64'hFFFF_FFFF_FFFF_FFC5;

  typedef struct {
    logic [63:0] x;
    logic [63:0] y;
    bit          inf;
  } point_t;

  typedef struct {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    int                    send_idle;
    int                    rx_stall;
    in_item_t              item;
  } job_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  ecc_stream_if #(.T(in_item_t)) in_ch();
  ecc_stream_if #(.T(out_item_t)) out_ch();

  ecc_affine_point_arith #(.FIELD_WIDTH(64)) DUT (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  job_t job_q[$];
  out_item_t expected_pts[$];
  logic [63:0] field_mod = 64'd3;
  logic [63:0] coef_a = 64'd0;
  int send_idle = 0;
  int rx_stall = 0;
  int mismatches = 0;
  longint unsigned cycles = 0;

  logic nxt_valid, nxt_we;
  in_item_t nxt_data;
  logic [CFG_IDX_W-1:0] nxt_idx;
  logic [CFG_DATA_W-1:0] nxt_val;
  job_t head;

  always #2 clk = ~clk;

  function automatic logic [63:0] fmul(logic [63:0] a, logic [63:0] b, logic [63:0] m);
    logic [127:0] prod;
    prod = a * b;
    return 64'(prod % m);
  endfunction

  function automatic logic [63:0] fadd(logic [63:0] a, logic [63:0] b, logic [63:0] m);
    logic [64:0] s;
    s = a + b;
    return 64'(s % m);
  endfunction

  function automatic logic [63:0] fsub(logic [63:0] a, logic [63:0] b, logic [63:0] m);
    return (a >= b) ? a - b : m - (b - a);
  endfunction

  function automatic logic [63:0] finv(logic [63:0] v, logic [63:0] m);
    logic [63:0] e, r, b;
    e = m - 64'd2;
    r = 64'd1 % m;
    b = v;
    while (e != 0) begin
      if (e[0]) r = fmul(r, b, m);
      b = fmul(b, b, m);
      e = e >> 1;
    end
    return r;
  endfunction

  function automatic point_t infinity();
    point_t r;
    r.x = 64'd0;
    r.y = 64'd1;
    r.inf = 1'b1;
    return r;
  endfunction

  function automatic point_t chord_end(logic [63:0] lam, logic [63:0] px, logic [63:0] py,
                                       logic [63:0] qx, logic [63:0] m);
    point_t r;
    r.x = fsub(fsub(fmul(lam, lam, m), px, m), qx, m);
    r.y = fsub(fmul(lam, fsub(px, r.x, m), m), py, m);
    r.inf = 1'b0;
    return r;
  endfunction

  function automatic point_t pt_double(point_t p, logic [63:0] m);
    logic [63:0] num, den;
    if (p.inf || p.y == 0) return infinity();
    num = fmul(p.x, p.x, m);
    num = fadd(fadd(fadd(num, num, m), num, m), coef_a % m, m);
    den = fadd(p.y, p.y, m);
    return chord_end(fmul(num, finv(den, m), m), p.x, p.y, p.x, m);
  endfunction

  function automatic point_t pt_sum(point_t p, point_t q, logic [63:0] m);
    logic [63:0] lam;
    if (p.inf) return q;
    if (q.inf) return p;
    if (p.x == q.x) begin
      if (p.y == q.y) return pt_double(p, m);
      return infinity();
    end
    lam = fmul(fsub(q.y, p.y, m), finv(fsub(q.x, p.x, m), m), m);
    return chord_end(lam, p.x, p.y, q.x, m);
  endfunction

  function automatic point_t pt_scale(point_t p, logic [63:0] k, logic [63:0] m);
    point_t acc;
    acc = infinity();
    while (k != 0 && !p.inf) begin
      if (k[0]) acc = pt_sum(acc, p, m);
      p = pt_double(p, m);
      k = k >> 1;
    end
    return acc;
  endfunction

  function automatic point_t load_point(logic [63:0] x, logic [63:0] y, logic flag,
                                        logic [63:0] m);
    point_t r;
    if (flag) return infinity();
    r.x = x % m;
    r.y = y % m;
    r.inf = 1'b0;
    return r;
  endfunction

  function automatic out_item_t point_result(in_item_t it);
    logic [63:0] m;
    point_t p, r;
    out_item_t o;
    m = (field_mod < 3) ? 64'd3 : field_mod;
    p = load_point(it.p_x, it.p_y, it.p_at_infinity, m);
    case (cmd_t'(it.cmd))
      CMD_ADD: r = pt_sum(p, load_point(it.q_x, it.q_y, it.q_at_infinity, m), m);
      CMD_DBL: r = pt_double(p, m);
      CMD_MUL: r = pt_scale(p, it.scalar, m);
      default: r = p;
    endcase
    if (r.inf) r = infinity();
    o.r_x = r.x;
    o.r_y = r.y;
    o.r_at_infinity = r.inf;
    return o;
  endfunction

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  task automatic push_cfg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val, int mode);
    job_t j;
    j.is_cfg = 1'b1;
    j.idx = idx;
    j.val = val;
    case (mode % 4)
      0: begin j.send_idle = 0;  j.rx_stall = 0;  end
      1: begin j.send_idle = 62; j.rx_stall = 0;  end
      2: begin j.send_idle = 0;  j.rx_stall = 62; end
      default: begin j.send_idle = 22; j.rx_stall = 22; end
    endcase
    j.item = '0;
    job_q.push_back(j);
  endtask

  task automatic push_point(cmd_t c, logic [63:0] px, logic [63:0] py, logic pi,
                            logic [63:0] qx, logic [63:0] qy, logic qi, logic [63:0] k);
    job_t j;
    j.is_cfg = 1'b0;
    j.idx = '0;
    j.val = '0;
    j.send_idle = 0;
    j.rx_stall = 0;
    j.item.cmd = c;
    j.item.p_x = px;
    j.item.p_y = py;
    j.item.p_at_infinity = pi;
    j.item.q_x = qx;
    j.item.q_y = qy;
    j.item.q_at_infinity = qi;
    j.item.scalar = k;
    job_q.push_back(j);
  endtask

  // most coordinates reduced; some unreduced, some partner points equal or negated
  task automatic push_random(logic [63:0] m, int scalar_bits);
    cmd_t c;
    logic [63:0] px, py, qx, qy, k;
    int pick;
    c = cmd_t'(($urandom_range(9) == 0) ? 3 : $urandom_range(2));
    px = ($urandom_range(4) == 0) ? rnd64() : rnd64() % m;
    py = ($urandom_range(4) == 0) ? rnd64() : rnd64() % m;
    if ($urandom_range(7) == 0) py = 64'd0;
    pick = $urandom_range(4);
    qx = (pick < 2) ? px % m : rnd64() % m;
    qy = (pick == 0) ? py % m : (pick == 1) ? (m - py % m) % m : rnd64();
    if ($urandom_range(5) == 0) qx = rnd64();
    k = rnd64();
    if (scalar_bits < 64) k = k & ((64'd1 << scalar_bits) - 1);
    push_point(c, px, py, $urandom_range(9) == 0, qx, qy, $urandom_range(9) == 0, k);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.data <= '0;
      cfg_we <= 1'b0;
      cfg_index <= '0;
      cfg_data <= '0;
    end else begin
      nxt_valid = in_ch.valid;
      nxt_data = in_ch.data;
      nxt_we = 1'b0;
      nxt_idx = cfg_index;
      nxt_val = cfg_data;
      if (in_ch.valid && in_ch.ready) begin
        expected_pts.push_back(point_result(in_ch.data));
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && !in_ch.valid && job_q.size() > 0) begin
        head = job_q[0];
        if (head.is_cfg) begin
          if (expected_pts.size() == 0) begin
            nxt_we = 1'b1;
            nxt_idx = head.idx;
            nxt_val = head.val;
            if (head.idx == CFG_MODULUS) field_mod = head.val;
            else coef_a = head.val;
            send_idle = head.send_idle;
            rx_stall <= head.rx_stall;
            void'(job_q.pop_front());
          end
        end else if ($urandom_range(99) >= send_idle) begin
          nxt_valid = 1'b1;
          nxt_data = head.item;
          void'(job_q.pop_front());
        end
      end
      in_ch.valid <= nxt_valid;
      in_ch.data <= nxt_data;
      cfg_we <= nxt_we;
      cfg_index <= nxt_idx;
      cfg_data <= nxt_val;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_pts.size() == 0) begin
          $error("unexpected transaction: r_x %h r_y %h r_at_infinity %b",
                 out_ch.data.r_x, out_ch.data.r_y, out_ch.data.r_at_infinity);
          mismatches++;
        end else begin
          if (out_ch.data.r_x !== expected_pts[0].r_x) begin
            $error("r_x: expected %h, actual %h", expected_pts[0].r_x, out_ch.data.r_x);
            mismatches++;
          end
          if (out_ch.data.r_y !== expected_pts[0].r_y) begin
            $error("r_y: expected %h, actual %h", expected_pts[0].r_y, out_ch.data.r_y);
            mismatches++;
          end
          if (out_ch.data.r_at_infinity !== expected_pts[0].r_at_infinity) begin
            $error("r_at_infinity: expected %b, actual %b",
                   expected_pts[0].r_at_infinity, out_ch.data.r_at_infinity);
            mismatches++;
          end
          void'(expected_pts.pop_front());
        end
      end
      out_ch.ready <= ($urandom_range(99) >= rx_stall);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    logic [63:0] mods[6];
    int bits[6];
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    mods = '{64'd97, 64'd0, BIG_PRIME, 64'd7, ALL_ONES, 64'd65521};
    bits = '{10, 64, 4, 64, 3, 8};

    push_cfg(CFG_MODULUS, 64'd97, 0);
    push_cfg(CFG_CURVE_A, 64'd2, 0);
    push_point(CMD_ADD, 64'd3, 64'd6, 1'b0, 64'd5, 64'd20, 1'b0, 64'd0);
    push_point(CMD_ADD, 64'd3, 64'd6, 1'b0, 64'd3, 64'd91, 1'b0, 64'd0);
    push_point(CMD_ADD, 64'd3, 64'd6, 1'b0, 64'd100, 64'd103, 1'b0, 64'd0);
    push_point(CMD_ADD, ALL_ONES, ALL_ONES, 1'b1, 64'd3, 64'd6, 1'b0, 64'd0);
    push_point(CMD_ADD, 64'd3, 64'd6, 1'b0, ALL_ONES, ALL_ONES, 1'b1, ALL_ONES);
    push_point(CMD_ADD, 64'd0, 64'd0, 1'b1, 64'd0, 64'd0, 1'b1, 64'd0);
    push_point(CMD_DBL, 64'd3, 64'd6, 1'b0, ALL_ONES, ALL_ONES, 1'b1, ALL_ONES);
    push_point(CMD_DBL, 64'd5, 64'd0, 1'b0, 64'd0, 64'd0, 1'b0, 64'd0);
    push_point(CMD_DBL, 64'd5, 64'd97, 1'b0, 64'd0, 64'd0, 1'b0, 64'd0);
    push_point(CMD_DBL, ALL_ONES, ALL_ONES, 1'b0, 64'd0, 64'd0, 1'b0, 64'd0);
    push_point(CMD_DBL, 64'd3, 64'd6, 1'b1, 64'd0, 64'd0, 1'b0, 64'd0);
    push_point(CMD_MUL, 64'd3, 64'd6, 1'b0, 64'd0, 64'd0, 1'b0, 64'd0);
    push_point(CMD_MUL, 64'd3, 64'd6, 1'b1, 64'd0, 64'd0, 1'b0, 64'd5);
    push_point(CMD_MUL, 64'd3, 64'd6, 1'b0, 64'd0, 64'd0, 1'b0, 64'd1);
    push_point(CMD_MUL, 64'd3, 64'd6, 1'b0, 64'd0, 64'd0, 1'b0, 64'd1000);
    push_point(CMD_MUL, 64'd3, 64'd6, 1'b0, 64'd0, 64'd0, 1'b0, ALL_ONES);
    push_point(CMD_PASS, ALL_ONES, 64'd200, 1'b0, ALL_ONES, ALL_ONES, 1'b1, ALL_ONES);
    push_point(CMD_PASS, 64'd1, 64'd2, 1'b1, 64'd0, 64'd0, 1'b0, 64'd0);
    push_cfg(CFG_CURVE_A, ALL_ONES, 1);
    push_point(CMD_DBL, 64'd3, 64'd6, 1'b0, 64'd0, 64'd0, 1'b0, 64'd0);
    push_point(CMD_ADD, 64'd4, 64'd6, 1'b0, 64'd4, 64'd6, 1'b0, 64'd0);

    for (int ph = 0; ph < 6; ph++) begin
      push_cfg(CFG_MODULUS, mods[ph], ph + 2);
      push_cfg(CFG_CURVE_A, (ph % 2) ? ALL_ONES : rnd64(), ph + 2);
      for (int n = 0; n < 16; n++)
        push_random((mods[ph] < 3) ? 64'd3 : mods[ph], bits[ph]);
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    while (job_q.size() > 0 || in_ch.valid || expected_pts.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ecc_pkg.sv
rtl/ecc_stream_if.sv
rtl/ecc_dp.sv
rtl/ecc_ctl.sv
rtl/ecc_affine_point_arith.sv
bench/ecc_affine_point_arith_tb.sv
